// File: rtl/core/dcme_pkg.sv
// ----------------------------------------------------------------------------
// dcme_pkg
// Types and constants shared by the drill cycle move expander modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dcme_pkg;

   // Coordinate format: signed micrometres
   localparam int unsigned COORD_BITS = 24;
   localparam int unsigned PECK_BITS  = 23;
   localparam int unsigned KIND_BITS  = 7;
   localparam int unsigned TAG_BITS   = 16;
   localparam int unsigned CSR_IDX_BITS = 3;

   // Canned cycle numbers with special handling
   localparam logic [KIND_BITS-1:0] KIND_PECK = 7'd83;
   localparam logic [KIND_BITS-1:0] KIND_TAP  = 7'd84;
   localparam logic [KIND_BITS-1:0] KIND_BORE = 7'd85;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_BITS-1:0] CSR_CYCLE_KIND  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RETRACT_Z   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REFERENCE_Z = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SAFETY_DIST = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOTTOM_Z    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PECK_DEPTH  = 3'd5;

   // Input command codes
   localparam logic CMD_DRILL   = 1'b0;
   localparam logic CMD_SET_POS = 1'b1;

   typedef struct packed {
      logic                          command;
      logic signed [COORD_BITS-1:0]  pos_x;
      logic signed [COORD_BITS-1:0]  pos_y;
      logic signed [COORD_BITS-1:0]  pos_z;
      logic [TAG_BITS-1:0]           tool_size;
      logic [TAG_BITS-1:0]           line_tag;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  move_x;
      logic signed [COORD_BITS-1:0]  move_y;
      logic signed [COORD_BITS-1:0]  move_z;
      logic                          is_rapid;
      logic [TAG_BITS-1:0]           tool_out;
      logic [TAG_BITS-1:0]           line_out;
      logic                          peck_overflow;
      logic                          last_move;
   } rsp_payload_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SAFE,
      ST_CLEAR,
      ST_PECK,
      ST_BACK,
      ST_FEED,
      ST_RETURN,
      ST_RETRACT,
      ST_FLUSH
   } state_type;

   // Z target of the candidate move
   typedef enum logic [1:0] {
      TGT_SAFE,
      TGT_CLEAR,
      TGT_PECK,
      TGT_BOTTOM
   } target_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      logic       set_pos;
      logic       take;
      logic       flush;
      logic       peck_step;
      target_type tgt;
      logic       rapid;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic skip;
      logic pend_valid;
      logic out_free;
      logic kind_peck;
      logic kind_ret;
      logic peck_active;
      logic peck_more;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/dcme_datapath.sv
// ----------------------------------------------------------------------------
// dcme_datapath
// Configuration registers, tool position, hole registers, candidate move
// generation, one-entry lookahead buffer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcme_datapath #(
   parameter int unsigned MAX_PECKS = 30
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire dcme_pkg::req_payload_type           req_payload,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [dcme_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [dcme_pkg::COORD_BITS-1:0]     csr_data,
   input  wire dcme_pkg::cmd_type                   cmd,
   output      dcme_pkg::status_type                status,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      dcme_pkg::rsp_payload_type           rsp_payload
);
   import dcme_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(MAX_PECKS + 1);
   localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(MAX_PECKS - 1);

   // Configuration registers
   logic [KIND_BITS-1:0]         kind_ff;
   logic signed [COORD_BITS-1:0] retract_ff;
   logic signed [COORD_BITS-1:0] ref_ff;
   logic signed [COORD_BITS-1:0] safety_ff;
   logic signed [COORD_BITS-1:0] bottom_ff;
   logic [PECK_BITS-1:0]         peck_ff;

   // Tool position
   logic signed [COORD_BITS-1:0] tool_x_ff, tool_y_ff, tool_z_ff;

   // Hole registers
   logic signed [COORD_BITS-1:0] hole_x_ff, hole_y_ff;
   logic [TAG_BITS-1:0]          tool_size_ff, line_ff;
   logic signed [COORD_BITS-1:0] clear_ff;
   logic signed [COORD_BITS-1:0] z_ff, z_in;
   logic [CNT_BITS-1:0]          cnt_ff;
   logic                         ovf_ff;

   // Lookahead and output stage
   rsp_payload_type pend_ff, out_ff;
   logic            pend_valid_ff, out_valid_ff;
   rsp_payload_type pend_last;

   logic signed [COORD_BITS:0]   clear_sum;
   logic signed [COORD_BITS-1:0] clear_sat;
   logic signed [COORD_BITS:0]   peck_diff;
   logic                         peck_below, peck_cap;
   logic signed [COORD_BITS-1:0] cand_z;
   logic                         cand_ovf;
   logic                         out_free;
   rsp_payload_type              cand;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_PECK;
         retract_ff <= 24'sd5000;
         ref_ff     <= '0;
         safety_ff  <= 24'sd2000;
         bottom_ff  <= -24'sd10000;
         peck_ff    <= 23'd5000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CYCLE_KIND:  kind_ff    <= csr_data[KIND_BITS-1:0];
            CSR_RETRACT_Z:   retract_ff <= csr_data;
            CSR_REFERENCE_Z: ref_ff     <= csr_data;
            CSR_SAFETY_DIST: safety_ff  <= csr_data;
            CSR_BOTTOM_Z:    bottom_ff  <= csr_data;
            CSR_PECK_DEPTH:  peck_ff    <= csr_data[PECK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the clearance plane
   always_comb begin
      clear_sum = {ref_ff[COORD_BITS-1], ref_ff} + {safety_ff[COORD_BITS-1], safety_ff};
      if (clear_sum[COORD_BITS] != clear_sum[COORD_BITS-1]) begin
         clear_sat = clear_sum[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                           : {1'b0, {(COORD_BITS-1){1'b1}}};
      end else begin
         clear_sat = clear_sum[COORD_BITS-1:0];
      end
   end

   // Next peck depth, clamped to bottom and capped by count
   always_comb begin
      peck_diff  = {z_ff[COORD_BITS-1], z_ff} - $signed({2'b00, peck_ff});
      peck_below = peck_diff < $signed({bottom_ff[COORD_BITS-1], bottom_ff});
      peck_cap   = (cnt_ff == CAP_CNT);
      z_in       = (peck_below || peck_cap) ? bottom_ff : peck_diff[COORD_BITS-1:0];
   end

   // Build the candidate move
   always_comb begin
      case (cmd.tgt)
         TGT_SAFE:   cand_z = retract_ff;
         TGT_CLEAR:  cand_z = clear_ff;
         TGT_PECK:   cand_z = z_in;
         TGT_BOTTOM: cand_z = bottom_ff;
         default:    cand_z = bottom_ff;
      endcase
      cand_ovf = ovf_ff || ((cmd.tgt == TGT_PECK) && peck_cap);
      cand.move_x        = hole_x_ff;
      cand.move_y        = hole_y_ff;
      cand.move_z        = cand_z;
      cand.is_rapid      = cmd.rapid;
      cand.tool_out      = tool_size_ff;
      cand.line_out      = line_ff;
      cand.peck_overflow = cand_ovf;
      cand.last_move     = 1'b0;
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   // Report status
   always_comb begin
      status.skip        = (hole_x_ff == tool_x_ff) && (hole_y_ff == tool_y_ff)
                           && (cand_z == tool_z_ff);
      status.pend_valid  = pend_valid_ff;
      status.out_free    = out_free;
      status.kind_peck   = (kind_ff == KIND_PECK);
      status.kind_ret    = (kind_ff == KIND_TAP) || (kind_ff == KIND_BORE);
      status.peck_active = z_ff > bottom_ff;
      status.peck_more   = z_in > bottom_ff;
   end

   // Track the tool position
   always_ff @(posedge clock) begin
      if (reset) begin
         tool_x_ff <= '0;
         tool_y_ff <= '0;
         tool_z_ff <= '0;
      end else if (cmd.set_pos) begin
         tool_x_ff <= req_payload.pos_x;
         tool_y_ff <= req_payload.pos_y;
         tool_z_ff <= req_payload.pos_z;
      end else if (cmd.take) begin
         tool_x_ff <= hole_x_ff;
         tool_y_ff <= hole_y_ff;
         tool_z_ff <= cand_z;
      end
   end

   // Capture the hole and advance the peck loop
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hole_x_ff    <= req_payload.pos_x;
         hole_y_ff    <= req_payload.pos_y;
         tool_size_ff <= req_payload.tool_size;
         line_ff      <= req_payload.line_tag;
         clear_ff     <= clear_sat;
         z_ff         <= clear_sat;
      end else if (cmd.peck_step) begin
         z_ff <= z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.peck_step) begin
         cnt_ff <= cnt_ff + 1'b1;
         ovf_ff <= cand_ovf;
      end
   end

   // Hold one move back so the final one can be marked
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.take) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pend_ff <= cand;
      end
   end

   // Mark the buffered move as the final one of the hole
   always_comb begin
      pend_last           = pend_ff;
      pend_last.last_move = 1'b1;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if ((cmd.take && pend_valid_ff) || cmd.flush) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && pend_valid_ff) begin
         out_ff <= pend_ff;
      end else if (cmd.flush) begin
         out_ff <= pend_last;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // Moving a buffered move out never overwrites an unread one
   a_take_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && pend_valid_ff) |-> out_free)
      else $error("dcme_datapath: move pushed into busy output register");

   a_flush_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> (pend_valid_ff && out_free && !cmd.take))
      else $error("dcme_datapath: flush without a buffered move or room");

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.peck_step |=> (cnt_ff <= CNT_BITS'(MAX_PECKS)))
      else $error("dcme_datapath: peck count beyond cap");

endmodule

`default_nettype wire

// File: rtl/core/dcme_ctrl.sv
// ----------------------------------------------------------------------------
// dcme_ctrl
// Sequencer for the canned cycle: walks the move list of one hole and
// decides when a candidate move is skipped, buffered or flushed.
// ----------------------------------------------------------------------------
`default_nettype none

module dcme_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_command,
   output      logic                  req_stall,
   input  wire dcme_pkg::status_type  status,
   output      dcme_pkg::cmd_type     cmd
);
   import dcme_pkg::*;

   state_type state_ff, state_in;
   logic      go;
   logic      accept;

   // A step may advance when its move is skipped or can be buffered
   assign go     = status.skip || !status.pend_valid || status.out_free;
   assign accept = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_DRILL)) state_in = ST_SAFE;
         end
         ST_SAFE: begin
            if (go) state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            if (go) state_in = status.kind_peck ? ST_PECK : ST_FEED;
         end
         ST_PECK: begin
            if (!status.peck_active) begin
               state_in = status.kind_ret ? ST_RETURN : ST_RETRACT;
            end else if (go) begin
               if (status.peck_more) state_in = ST_BACK;
               else state_in = status.kind_ret ? ST_RETURN : ST_RETRACT;
            end
         end
         ST_BACK: begin
            if (go) state_in = ST_PECK;
         end
         ST_FEED: begin
            if (go) state_in = status.kind_ret ? ST_RETURN : ST_RETRACT;
         end
         ST_RETURN: begin
            if (go) state_in = ST_RETRACT;
         end
         ST_RETRACT: begin
            if (go) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!status.pend_valid || status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd           = '0;
      cmd.tgt       = TGT_SAFE;
      cmd.rapid     = 1'b1;
      req_stall     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load    = accept && (req_command == CMD_DRILL);
            cmd.set_pos = accept && (req_command == CMD_SET_POS);
         end
         ST_SAFE: begin
            cmd.tgt  = TGT_SAFE;
            cmd.take = go && !status.skip;
         end
         ST_CLEAR: begin
            cmd.tgt  = TGT_CLEAR;
            cmd.take = go && !status.skip;
         end
         ST_PECK: begin
            cmd.tgt       = TGT_PECK;
            cmd.rapid     = 1'b0;
            cmd.take      = status.peck_active && go && !status.skip;
            cmd.peck_step = status.peck_active && go;
         end
         ST_BACK: begin
            cmd.tgt  = TGT_CLEAR;
            cmd.take = go && !status.skip;
         end
         ST_FEED: begin
            cmd.tgt   = TGT_BOTTOM;
            cmd.rapid = 1'b0;
            cmd.take  = go && !status.skip;
         end
         ST_RETURN: begin
            cmd.tgt   = TGT_CLEAR;
            cmd.rapid = 1'b0;
            cmd.take  = go && !status.skip;
         end
         ST_RETRACT: begin
            cmd.tgt  = TGT_SAFE;
            cmd.take = go && !status.skip;
         end
         ST_FLUSH: begin
            cmd.flush = status.pend_valid && status.out_free;
         end
         default: ;
      endcase
   end

   // Input is taken only between holes
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load || cmd.set_pos) |-> (state_ff == ST_IDLE))
      else $error("dcme_ctrl: item taken while a hole is in progress");

   a_load_next: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_SAFE))
      else $error("dcme_ctrl: hole did not start with the safe rapid");

   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (state_ff == ST_IDLE))
      else $error("dcme_ctrl: flush did not end the hole");

endmodule

`default_nettype wire

// File: rtl/core/drill_cycle_move_expander_unit.sv
// Throughput: one move per cycle while the consumer keeps up; the sequencer steps
// one candidate move per cycle while it can be skipped or buffered, and the next item
// waits until the hole's last move leaves the lookahead stage.
// Reset: synchronous, active high; configuration registers return to their documented values and
// the tool position to zero.
// ----------------------------------------------------------------------------
// drill_cycle_move_expander_unit
// Expands a hole request into the moves of a G81 to G85 style canned cycle,
// with peck drilling for kind 83, and keeps the current tool position.
// ----------------------------------------------------------------------------
`default_nettype none

module drill_cycle_move_expander_unit #(
   parameter int unsigned MAX_PECKS = 30
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire dcme_pkg::req_payload_type          req_payload,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      dcme_pkg::rsp_payload_type          rsp_payload,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [dcme_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [dcme_pkg::COORD_BITS-1:0]    csr_data
);
   import dcme_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   dcme_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   dcme_datapath #(
      .MAX_PECKS (MAX_PECKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
